// ===== design/rps_pkg.sv =====
// rps_pkg: shared constants and types of the permutation shuffle block
// no dependencies; imported by rps_out_if and every module of the block
package rps_pkg;

	localparam int CFG_W   = 11;
	localparam int VAL_W   = 10;
	localparam int EPOCH_W = 8;

	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef struct packed {
		logic rd_en;
		logic val_we;
		logic tag_we;
	} store_ctl_t;

endpackage

// ===== design/rps_if.sv =====
// rps_if: valid/ready channels of the permutation shuffle block
// depends on rps_pkg for the result field width
interface rps_in_if #(
	parameter int W = 31
);
	logic         valid;
	logic         ready;
	logic [W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

interface rps_out_if;
	import rps_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] perm_value;
	logic             is_last;

	modport source (output valid, output perm_value, output is_last, input ready);
	modport sink   (input valid, input perm_value, input is_last, output ready);
endinterface

// ===== design/rps_mod_unit.sv =====
// rps_mod_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on rps_pkg; used by random_permutation_shuffle
module rps_mod_unit #(
	parameter int DW = 31,
	parameter int MW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [MW-1:0] divisor,
	output logic          done,
	output logic [MW-1:0] rem
);
	import rps_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [MW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [MW:0]   trial;
	logic [MW:0]   diff;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= diff[MW] ? trial[MW-1:0] : diff[MW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < divisor)
		else $error("remainder not below divisor");

endmodule

// ===== design/rps_store.sv =====
// rps_store: entry value memory and written-epoch tag memory
// depends on rps_pkg for the control struct; used by random_permutation_shuffle
module rps_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int EW    = 8
) (
	input  logic                clk,
	input  rps_pkg::store_ctl_t ctl,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       wr_val,
	input  logic [EW-1:0]       wr_tag,
	output logic [AW-1:0]       rd_val,
	output logic [EW-1:0]       rd_tag
);
	import rps_pkg::*;

	logic [AW-1:0] val_mem [DEPTH];
	logic [EW-1:0] tag_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[wr_addr] <= wr_val;
		end
		if (ctl.rd_en) begin
			rd_val <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tag_we) begin
			tag_mem[wr_addr] <= wr_tag;
		end
		if (ctl.rd_en) begin
			rd_tag <= tag_mem[rd_addr];
		end
	end

endmodule

// ===== design/random_permutation_shuffle.sv =====
// random_permutation_shuffle: fisher-yates shuffle, one output beat per input beat
// depends on rps_pkg, rps_if, rps_mod_unit and rps_store
// an input beat passes the remainder, two store reads and two store writes, then
// the result is pushed into the output register; a new beat is taken only in idle
// after that push, and the output register lets the next beat in while it waits
// reset: tag clearing pass over all PERM_DEPTH entries, repeated after every 255 restarts
module random_permutation_shuffle #(
	parameter int PERM_DEPTH = 1024,
	parameter int RAND_BITS  = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rps_pkg::CFG_W-1:0]  cfg_wdata,
	rps_in_if.sink                     rand_in,
	rps_out_if.source                  perm_out
);
	import rps_pkg::*;

	localparam int AW       = $clog2(PERM_DEPTH);
	localparam int NW       = $clog2(PERM_DEPTH + 1);
	localparam int CW       = (NW > CFG_W) ? NW : CFG_W;
	localparam int LenReset = (PERM_DEPTH < 1024) ? PERM_DEPTH : 1024;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_RD_I,
		S_RD_J,
		S_WR_I,
		S_WR_J,
		S_PUSH
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] len_q;
	logic [AW-1:0]    pos_q;
	epoch_t           epoch_q;
	logic [AW-1:0]    clr_q;
	logic [NW-1:0]    n_q;
	logic [AW-1:0]    j_q;
	logic [AW-1:0]    vi_q;
	logic [AW-1:0]    vj_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_last_q;

	logic [CW-1:0]    len_ext;
	logic [NW-1:0]    n_eff;
	logic [NW-1:0]    pos_ext;
	logic             accept;
	logic             mod_done;
	logic [NW-1:0]    mod_rem;
	logic [NW-1:0]    j_sum;
	logic             last;
	logic             out_free;

	store_ctl_t       st_ctl;
	logic [AW-1:0]    st_rd_addr;
	logic [AW-1:0]    st_wr_addr;
	logic [AW-1:0]    st_wr_val;
	epoch_t           st_wr_tag;
	logic [AW-1:0]    st_rd_val;
	epoch_t           st_rd_tag;
	logic [AW-1:0]    vi_now;
	logic [AW-1:0]    vj_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= CFG_W'(LenReset);
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	assign len_ext = CW'(len_q);

	always_comb begin
		if (len_q == '0) begin
			n_eff = NW'(1);
		end else if (len_ext > CW'(PERM_DEPTH)) begin
			n_eff = NW'(PERM_DEPTH);
		end else begin
			n_eff = NW'(len_ext);
		end
	end

	assign pos_ext       = NW'(pos_q);
	assign rand_in.ready = (state_q == S_IDLE) && (pos_ext < n_eff);
	assign accept        = rand_in.valid && rand_in.ready;
	assign j_sum         = pos_ext + mod_rem;
	assign last          = (pos_ext == n_q - 1'b1);
	assign out_free      = !out_valid_q || perm_out.ready;

	rps_mod_unit #(
		.DW(RAND_BITS),
		.MW(NW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.dividend(rand_in.random_word),
		.divisor (n_q - pos_ext),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// unwritten entries of this epoch read as their own index
	assign vi_now = (st_rd_tag == epoch_q) ? st_rd_val : pos_q;
	assign vj_now = (st_rd_tag == epoch_q) ? st_rd_val : j_q;

	always_comb begin
		st_ctl     = '0;
		st_rd_addr = pos_q;
		st_wr_addr = pos_q;
		st_wr_val  = vj_now;
		st_wr_tag  = epoch_q;
		case (state_q)
			S_CLEAR: begin
				st_ctl.tag_we = 1'b1;
				st_wr_addr    = clr_q;
				st_wr_tag     = '0;
			end
			S_RD_I: begin
				st_ctl.rd_en = 1'b1;
			end
			S_RD_J: begin
				st_ctl.rd_en = 1'b1;
				st_rd_addr   = j_q;
			end
			S_WR_I: begin
				st_ctl.val_we = 1'b1;
				st_ctl.tag_we = 1'b1;
			end
			S_WR_J: begin
				st_ctl.val_we = 1'b1;
				st_ctl.tag_we = 1'b1;
				st_wr_addr    = j_q;
				st_wr_val     = vi_q;
			end
			default: begin
				st_ctl = '0;
			end
		endcase
	end

	rps_store #(
		.DEPTH(PERM_DEPTH),
		.AW   (AW),
		.EW   (EPOCH_W)
	) u_store (
		.clk    (clk),
		.ctl    (st_ctl),
		.rd_addr(st_rd_addr),
		.wr_addr(st_wr_addr),
		.wr_val (st_wr_val),
		.wr_tag (st_wr_tag),
		.rd_val (st_rd_val),
		.rd_tag (st_rd_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pos_q       <= '0;
			epoch_q     <= EPOCH_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_PUSH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && perm_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(PERM_DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						n_q     <= n_eff;
						state_q <= S_DIV;
					end else if (rand_in.valid && (pos_ext >= n_eff)) begin
						// length shrank below the position: fresh permutation
						pos_q <= '0;
						if (epoch_q == '1) begin
							epoch_q <= EPOCH_W'(1);
							state_q <= S_CLEAR;
						end else begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
				end
				S_DIV: begin
					if (mod_done) begin
						j_q     <= AW'(j_sum);
						state_q <= S_RD_I;
					end
				end
				S_RD_I: begin
					state_q <= S_RD_J;
				end
				S_RD_J: begin
					vi_q    <= vi_now;
					state_q <= S_WR_I;
				end
				S_WR_I: begin
					vj_q    <= vj_now;
					state_q <= S_WR_J;
				end
				S_WR_J: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						out_val_q  <= VAL_W'(vj_q);
						out_last_q <= last;
						if (last) begin
							pos_q <= '0;
							if (epoch_q == '1) begin
								epoch_q <= EPOCH_W'(1);
								state_q <= S_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign perm_out.valid      = out_valid_q;
	assign perm_out.perm_value = out_val_q;
	assign perm_out.is_last    = out_last_q;

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("epoch tag collides with cleared tag");

	a_accept_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> pos_ext < n_eff)
		else $error("beat accepted past the end of the permutation");

	a_swap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_I |-> (j_q >= pos_q) && (NW'(j_q) < n_q))
		else $error("swap index outside the open range");

	a_push_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) && out_valid_q && !perm_out.ready |=> state_q == S_PUSH)
		else $error("result overwrote a beat still waiting");

endmodule
